// ===== src/multichannel_oversample_fir_decimator_top_macros.svh =====
// Assertion macros shared by the decimator RTL.
`ifndef MULTICHANNEL_OVERSAMPLE_FIR_DECIMATOR_TOP_MACROS_SVH
`define MULTICHANNEL_OVERSAMPLE_FIR_DECIMATOR_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MOFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define MOFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mofd_pkg.sv =====
// Shared types and constants of the oversampling FIR decimator.
`default_nettype none

package mofd_pkg;

   localparam int unsigned DEF_CHANNELS       = 8;
   localparam int unsigned DEF_MAX_OVERSAMPLE = 32;
   localparam int unsigned DEF_PAD_TO_EVEN    = 0;

   localparam int unsigned SAMPLE_W = 12;
   localparam int unsigned CIDX_W   = 6;
   localparam int unsigned COEF_W   = 16;
   localparam int unsigned OSC_W    = 6;
   localparam int unsigned CHAN_W   = 3;
   localparam int unsigned ACC_W    = 32;
   localparam int unsigned VAL_W    = 40;
   localparam int unsigned FRAC_W   = 8;
   localparam int unsigned PROD_W   = 29;
   localparam int unsigned DIV_STEPS = VAL_W;
   localparam int unsigned STEP_W   = $clog2(DIV_STEPS + 1);

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_COEF   = 1'b1;

   localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;
   localparam logic signed [VAL_W-1:0] VAL_MAX = 40'sh7F_FFFF_FFFF;

   typedef struct packed {
      logic                     mode;
      logic [SAMPLE_W-1:0]      sample;
      logic [CIDX_W-1:0]        coef_index;
      logic signed [COEF_W-1:0] coef_value;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0]       channel;
      logic signed [VAL_W-1:0] filtered_value;
      logic                    divide_by_zero;
      logic                    last;
   } rsp_type;

   // Control bundle for a memory with per-entry valid bits.
   typedef struct packed {
      logic wr_en;
      logic rd_en;
      logic clear;
   } mem_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_ACCUM,
      ST_NORM_RD,
      ST_NORM,
      ST_CH_RD,
      ST_CH_DIV,
      ST_DIV_WAIT,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== src/mofd_coef_mem.sv =====
// Coefficient memory with valid bits; unwritten entries read as the boxcar.
`default_nettype none

module mofd_coef_mem #(
   parameter int unsigned DEPTH = mofd_pkg::DEF_MAX_OVERSAMPLE + 1,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mofd_pkg::mem_ctl_type             ctl,
   input  wire logic [AW-1:0]                     wr_addr,
   input  wire logic signed [mofd_pkg::COEF_W-1:0] wr_data,
   input  wire logic [AW-1:0]                     rd_addr,
   input  wire logic [AW-1:0]                     count,
   output logic signed [mofd_pkg::COEF_W-1:0]     rd_data
);
   import mofd_pkg::*;

   logic signed [COEF_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]         vld_ff;
   logic signed [COEF_W-1:0] rd_data_ff;
   logic                     rd_vld_ff;
   logic [AW-1:0]            rd_addr_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // clear = boxcar reload: every entry falls back to its default
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_comb begin
      if (rd_vld_ff) begin
         rd_data = rd_data_ff;
      end else if (rd_addr_ff == count) begin
         rd_data = signed'(COEF_W'(count));
      end else begin
         rd_data = COEF_W'(1);
      end
   end

endmodule

`default_nettype wire

// ===== src/mofd_acc_mem.sv =====
// Per-channel accumulator memory; a clear zeroes every entry at once.
`default_nettype none

module mofd_acc_mem #(
   parameter int unsigned DEPTH = mofd_pkg::DEF_CHANNELS,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire mofd_pkg::mem_ctl_type              ctl,
   input  wire logic [AW-1:0]                      wr_addr,
   input  wire logic signed [mofd_pkg::ACC_W-1:0]  wr_data,
   input  wire logic [AW-1:0]                      rd_addr,
   output logic signed [mofd_pkg::ACC_W-1:0]       rd_data
);
   import mofd_pkg::*;

   logic signed [ACC_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]        vld_ff;
   logic signed [ACC_W-1:0] rd_data_ff;
   logic                    rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (ctl.rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

// ===== src/mofd_divider.sv =====
// Radix-2 restoring signed divider, one quotient bit per cycle, truncating.
`default_nettype none

module mofd_divider (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic signed [mofd_pkg::VAL_W-1:0]  dividend,
   input  wire logic signed [mofd_pkg::COEF_W-1:0] divisor,
   output logic                                    busy,
   output logic signed [mofd_pkg::VAL_W-1:0]       quotient
);
   import mofd_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [COEF_W-1:0] rem_ff, rem_in;
   logic [VAL_W-1:0]  q_ff, q_in;
   logic [COEF_W-1:0] dvs_ff, dvs_in;
   logic              neg_ff, neg_in;

   logic [COEF_W:0] shifted;
   logic [COEF_W:0] diff;
   logic            fits;

   always_comb begin
      shifted = {rem_ff, q_ff[VAL_W-1]};
      diff    = shifted - {1'b0, dvs_ff};
      fits    = (shifted >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;

      if (start) begin
         // work on magnitudes; the most negative values map onto 2^(n-1)
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         q_in    = dividend[VAL_W-1] ? VAL_W'(-dividend) : VAL_W'(dividend);
         dvs_in  = divisor[COEF_W-1] ? COEF_W'(-divisor) : COEF_W'(divisor);
         neg_in  = dividend[VAL_W-1] ^ divisor[COEF_W-1];
      end else if (busy_ff) begin
         rem_in  = fits ? diff[COEF_W-1:0] : shifted[COEF_W-1:0];
         q_in    = {q_ff[VAL_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
   end

   // only +2^39 overflows (most negative sum over -1)
   always_comb begin
      if (neg_ff) begin
         quotient = signed'(-q_ff);
      end else if (q_ff[VAL_W-1]) begin
         quotient = VAL_MAX;
      end else begin
         quotient = signed'(q_ff);
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

// ===== src/multichannel_oversample_fir_decimator_top.sv =====
// Top level of the multichannel oversampling FIR decimator.
`default_nettype none

`include "multichannel_oversample_fir_decimator_top_macros.svh"

// Weighted block averager for channel-interleaved 12-bit converter samples.
// Each sample request goes to the next slot of a frame (one slot per channel,
// plus a trailing ignored pad slot when PAD_TO_EVEN is set and CHANNELS is
// odd). A channel accumulates sample * coef[frame] with int32 saturation.
// After oversample_count frames the block emits CHANNELS results, in channel
// order, last set on the final one: (sum * 256) / coef[oversample_count],
// truncated toward zero, 8 fraction bits; a zero normalizer gives value 0
// with divide_by_zero set. Mode-1 requests write one coefficient (ignored
// when the index is above oversample_count) and take effect from the next
// sample. Writing oversample_count (0 reads as 1, clamped to MAX_OVERSAMPLE)
// reloads the boxcar (ones, normalizer = count) and restarts the block.
// Coefficient requests are taken in IDLE; a sample request steps through a
// memory read, a multiply and the accumulate/write-back to the accumulator
// memory. The request closing a block adds an output pass that reads the
// normalizer and then, per channel, an accumulator read, a divider start,
// the bit-serial 40-step divider, a done check and the emit (no divider
// with a zero normalizer), plus any stall on the result channel. Only one
// request is in flight, so the read-modify-write of an accumulator never
// overlaps another access. No clearing pass after reset: both memories use
// per-entry valid bits.
module multichannel_oversample_fir_decimator_top #(
   parameter int unsigned CHANNELS       = mofd_pkg::DEF_CHANNELS,
   parameter int unsigned MAX_OVERSAMPLE = mofd_pkg::DEF_MAX_OVERSAMPLE,
   parameter int unsigned PAD_TO_EVEN    = mofd_pkg::DEF_PAD_TO_EVEN
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   // sample / coefficient requests
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire mofd_pkg::req_type           req_data,
   // filtered results
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output mofd_pkg::rsp_type                rsp_data,
   // oversample_count register
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [mofd_pkg::OSC_W-1:0]  csr_data
);
   import mofd_pkg::*;

   localparam int unsigned SLOTS  = CHANNELS + (((PAD_TO_EVEN != 0) && (CHANNELS % 2 != 0)) ? 1 : 0);
   localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CW     = $clog2(MAX_OVERSAMPLE + 1);

   // control state
   state_type          state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [CW-1:0]      frame_ff, frame_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CH_W-1:0]    chan_ff, chan_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [SAMPLE_W-1:0]      sample_ff, sample_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [COEF_W-1:0] norm_ff, norm_in;
   logic                     zero_ff, zero_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // memory and divider hookup
   mem_ctl_type              coef_ctl;
   logic [CW-1:0]            coef_wr_addr;
   logic [CW-1:0]            coef_rd_addr;
   logic signed [COEF_W-1:0] coef_rd_data;
   mem_ctl_type              acc_ctl;
   logic [CH_W-1:0]          acc_wr_addr;
   logic [CH_W-1:0]          acc_rd_addr;
   logic signed [ACC_W-1:0]  acc_wr_data;
   logic signed [ACC_W-1:0]  acc_rd_data;
   logic                     div_start;
   logic                     div_busy;
   logic signed [VAL_W-1:0]  div_dividend;
   logic signed [VAL_W-1:0]  div_quotient;

   logic                     req_accept;
   logic                     cfg_wr;
   logic                     slot_is_chan;
   logic                     rsp_free;
   logic                     chan_last;
   logic signed [PROD_W-1:0] smp_ext;
   logic signed [PROD_W-1:0] coef_ext;
   logic signed [ACC_W+1:0]  sum_w;
   logic [CW-1:0]            count_wr;

   assign req_stall  = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign cfg_wr     = csr_valid && csr_ready;

   assign slot_is_chan = (32'(slot_ff) < CHANNELS);
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign chan_last    = (chan_ff == CH_W'(CHANNELS - 1));

   // register write value: zero means one, clamp to the table size
   always_comb begin
      if (csr_data == '0) begin
         count_wr = CW'(1);
      end else if (32'(csr_data) > MAX_OVERSAMPLE) begin
         count_wr = CW'(MAX_OVERSAMPLE);
      end else begin
         count_wr = CW'(csr_data);
      end
   end

   // multiply-accumulate datapath
   assign smp_ext      = PROD_W'({1'b0, sample_ff});
   assign coef_ext     = PROD_W'(coef_rd_data);
   assign sum_w        = (ACC_W + 2)'(acc_rd_data) + (ACC_W + 2)'(prod_ff);
   assign div_dividend = signed'({acc_rd_data, FRAC_W'(0)});

   always_comb begin
      if (sum_w > (ACC_W + 2)'(ACC_MAX)) begin
         acc_wr_data = ACC_MAX;
      end else if (sum_w < (ACC_W + 2)'(ACC_MIN)) begin
         acc_wr_data = ACC_MIN;
      end else begin
         acc_wr_data = ACC_W'(sum_w);
      end
   end

   // sequencer: next state, counters and memory controls
   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      frame_in     = frame_ff;
      count_in     = count_ff;
      chan_in      = chan_ff;
      sample_in    = sample_ff;
      prod_in      = prod_ff;
      norm_in      = norm_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      coef_ctl     = '0;
      coef_wr_addr = CW'(req_data.coef_index);
      coef_rd_addr = frame_ff;
      acc_ctl      = '0;
      acc_wr_addr  = CH_W'(slot_ff);
      acc_rd_addr  = CH_W'(slot_ff);
      div_start    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cfg_wr) begin
               count_in       = count_wr;
               coef_ctl.clear = 1'b1;
               acc_ctl.clear  = 1'b1;
               slot_in        = '0;
               frame_in       = '0;
            end else if (req_accept) begin
               if (req_data.mode == MODE_COEF) begin
                  coef_ctl.wr_en = (32'(req_data.coef_index) <= 32'(count_ff));
               end else begin
                  sample_in      = req_data.sample;
                  coef_ctl.rd_en = 1'b1;
                  acc_ctl.rd_en  = 1'b1;
                  state_in       = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            prod_in  = smp_ext * coef_ext;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            acc_ctl.wr_en = slot_is_chan;
            state_in      = ST_IDLE;
            if (slot_ff == SLOT_W'(SLOTS - 1)) begin
               slot_in = '0;
               if (frame_ff == CW'(count_ff - CW'(1))) begin
                  frame_in = '0;
                  state_in = ST_NORM_RD;
               end else begin
                  frame_in = frame_ff + CW'(1);
               end
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
         ST_NORM_RD: begin
            coef_rd_addr   = count_ff;
            coef_ctl.rd_en = 1'b1;
            chan_in        = '0;
            state_in       = ST_NORM;
         end
         ST_NORM: begin
            norm_in  = coef_rd_data;
            state_in = ST_CH_RD;
         end
         ST_CH_RD: begin
            acc_rd_addr   = chan_ff;
            acc_ctl.rd_en = 1'b1;
            state_in      = ST_CH_DIV;
         end
         ST_CH_DIV: begin
            zero_in = (norm_ff == '0);
            if (norm_ff == '0) begin
               state_in = ST_EMIT;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV_WAIT;
            end
         end
         ST_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.channel        = CHAN_W'(chan_ff);
               rsp_data_in.filtered_value = zero_ff ? '0 : div_quotient;
               rsp_data_in.divide_by_zero = zero_ff;
               rsp_data_in.last           = chan_last;
               if (chan_last) begin
                  acc_ctl.clear = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  chan_in  = chan_ff + CH_W'(1);
                  state_in = ST_CH_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         frame_ff     <= '0;
         count_ff     <= CW'(MAX_OVERSAMPLE);
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         frame_ff     <= frame_in;
         count_ff     <= count_in;
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      prod_ff     <= prod_in;
      norm_ff     <= norm_in;
      zero_ff     <= zero_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   mofd_coef_mem #(
      .DEPTH (MAX_OVERSAMPLE + 1),
      .AW    (CW)
   ) u_coef_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (coef_ctl),
      .wr_addr (coef_wr_addr),
      .wr_data (req_data.coef_value),
      .rd_addr (coef_rd_addr),
      .count   (count_ff),
      .rd_data (coef_rd_data)
   );

   mofd_acc_mem #(
      .DEPTH (CHANNELS),
      .AW    (CH_W)
   ) u_acc_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .wr_addr (acc_wr_addr),
      .wr_data (acc_wr_data),
      .rd_addr (acc_rd_addr),
      .rd_data (acc_rd_data)
   );

   mofd_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (norm_ff),
      .busy     (div_busy),
      .quotient (div_quotient)
   );

   // a sample request always enters the read-modify-write sequence
   `MOFD_ASSERT_NEXT(a_sample_fetch, clock, reset, req_accept && (req_data.mode == MODE_SAMPLE), state_ff == ST_FETCH, "sample request did not start a fetch")
   // the divider is never restarted while it still works
   `MOFD_ASSERT_NOW(a_div_idle_start, clock, reset, div_start, !div_busy, "divider started while busy")
   // a register write restarts the block
   `MOFD_ASSERT_NEXT(a_cfg_restart, clock, reset, cfg_wr, (slot_ff == '0) && (frame_ff == '0), "register write left counters running")
   // the frame index stays inside the current block
   `MOFD_ASSERT_NOW(a_frame_range, clock, reset, state_ff == ST_IDLE, frame_ff < count_ff, "frame index beyond oversample count")

endmodule

`default_nettype wire
